@@ rtl/core/tpls_pkg.sv @@
// shared types and constants for the piecewise linear scaling block
`timescale 1ns / 1ps
package tpls_pkg;

    localparam int DEF_MAX_POINTS = 16;
    localparam int DEF_VALUE_BITS = 16;

    localparam int CMD_W       = 1;
    localparam int INDEX_W     = 4;
    localparam int COUNT_REG_W = 5;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [CMD_W-1:0] CMD_WRITE   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_CONVERT = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_POINT_COUNT = 1'b0;

    // control flags that travel along the cell chain with a convert word
    typedef struct packed {
        logic valid;
        logic done;
        logic exact;
        logic pend;
    } tpls_ctl_t;

endpackage

@@ rtl/core/tpls_cell.sv @@
// one table cell: holds a point and checks the passing convert word against it
`timescale 1ns / 1ps
module tpls_cell
    import tpls_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int CNT_W      = $clog2(MAX_POINTS + 1)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic signed [VALUE_BITS-1:0] wr_x,
    input  logic signed [VALUE_BITS-1:0] wr_y,
    input  logic [CNT_W-1:0]             n_eff,
    input  tpls_ctl_t                    ctl_in,
    input  logic signed [VALUE_BITS-1:0] x_in,
    input  logic signed [VALUE_BITS-1:0] xa_in,
    input  logic signed [VALUE_BITS-1:0] ya_in,
    input  logic signed [VALUE_BITS-1:0] xb_in,
    input  logic signed [VALUE_BITS-1:0] yb_in,
    output tpls_ctl_t                    ctl_out,
    output logic signed [VALUE_BITS-1:0] x_out,
    output logic signed [VALUE_BITS-1:0] xa_out,
    output logic signed [VALUE_BITS-1:0] ya_out,
    output logic signed [VALUE_BITS-1:0] xb_out,
    output logic signed [VALUE_BITS-1:0] yb_out
);

    logic signed [VALUE_BITS-1:0] px_reg;
    logic signed [VALUE_BITS-1:0] py_reg;

    tpls_ctl_t                    ctl_reg, ctl_next;
    logic signed [VALUE_BITS-1:0] x_reg;
    logic signed [VALUE_BITS-1:0] xa_reg, xa_next;
    logic signed [VALUE_BITS-1:0] ya_reg, ya_next;
    logic signed [VALUE_BITS-1:0] xb_reg, xb_next;
    logic signed [VALUE_BITS-1:0] yb_reg, yb_next;

    logic active;
    logic has_next;

    assign active   = CNT_W'(IDX) < n_eff;
    assign has_next = CNT_W'(IDX + 1) < n_eff;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            px_reg <= wr_x;
            py_reg <= wr_y;
        end
    end

    always_comb
    begin
        ctl_next = ctl_in;
        xa_next  = xa_in;
        ya_next  = ya_in;
        xb_next  = xb_in;
        yb_next  = yb_in;
        if (ctl_in.valid && active)
        begin
            if (!ctl_in.done)
            begin
                if (x_in == px_reg)
                begin
                    ctl_next.done  = 1'b1;
                    ctl_next.exact = 1'b1;
                    ya_next        = py_reg;
                end
                else if (x_in < px_reg)
                begin
                    ctl_next.done = 1'b1;
                    if (IDX > 0)
                    begin
                        // segment from the previous point, already in xa/ya
                        xb_next = px_reg;
                        yb_next = py_reg;
                    end
                    else if (has_next)
                    begin
                        // below the first point: wait for the second one
                        xa_next       = px_reg;
                        ya_next       = py_reg;
                        ctl_next.pend = 1'b1;
                    end
                    else
                    begin
                        // lone point, paired with the origin
                        xa_next = '0;
                        ya_next = '0;
                        xb_next = px_reg;
                        yb_next = py_reg;
                    end
                end
                else
                begin
                    // carry this point on as the previous one
                    xa_next = px_reg;
                    ya_next = py_reg;
                end
            end
            else if (ctl_in.pend)
            begin
                xb_next       = px_reg;
                yb_next       = py_reg;
                ctl_next.pend = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= x_in;
        xa_reg <= xa_next;
        ya_reg <= ya_next;
        xb_reg <= xb_next;
        yb_reg <= yb_next;
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign xa_out  = xa_reg;
    assign ya_out  = ya_reg;
    assign xb_out  = xb_reg;
    assign yb_out  = yb_reg;

endmodule

@@ rtl/core/tpls_line.sv @@
// line evaluation: multiply, bit-serial divide and saturation
`timescale 1ns / 1ps
module tpls_line
    import tpls_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         direct,
    input  logic signed [VALUE_BITS-1:0] direct_value,
    input  logic signed [VALUE_BITS-1:0] x,
    input  logic signed [VALUE_BITS-1:0] xa,
    input  logic signed [VALUE_BITS-1:0] ya,
    input  logic signed [VALUE_BITS-1:0] xb,
    input  logic signed [VALUE_BITS-1:0] yb,
    input  logic                         take,
    output logic                         res_valid,
    output logic signed [VALUE_BITS-1:0] res_value,
    output logic                         res_sat
);

    localparam int DIFF_W = VALUE_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int CNT_W  = $clog2(PROD_W);
    localparam int R_W    = PROD_W + 2;
    localparam logic signed [R_W-1:0] HI = (R_W'(1) << (VALUE_BITS - 1)) - R_W'(1);
    localparam logic signed [R_W-1:0] LO = -HI - R_W'(1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_DONE = 5'b10000
    } line_state_t;

    line_state_t state_reg, state_next;

    logic [DIFF_W-1:0]            dx_mag_reg, rise_mag_reg, run_mag_reg;
    logic                         neg_reg;
    logic                         zero_run_reg;
    logic signed [VALUE_BITS-1:0] ya_reg;
    logic [PROD_W-1:0]            quo_reg;
    logic [DIFF_W-1:0]            rem_reg;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic signed [VALUE_BITS-1:0] value_reg;
    logic                         sat_reg;

    logic signed [DIFF_W-1:0] dx, rise, run;
    logic [DIFF_W+1:0]        trial;
    logic                     fits;
    logic signed [R_W-1:0]    sq, r;

    assign dx   = DIFF_W'(x)  - DIFF_W'(xa);
    assign rise = DIFF_W'(yb) - DIFF_W'(ya);
    assign run  = DIFF_W'(xb) - DIFF_W'(xa);

    // one restoring step per cycle, quotient shifted in from the bottom
    assign trial = {1'b0, rem_reg, quo_reg[PROD_W-1]} - {2'b00, run_mag_reg};
    assign fits  = !trial[DIFF_W+1];

    assign sq = neg_reg ? -R_W'(quo_reg) : R_W'(quo_reg);
    assign r  = R_W'(ya_reg) + sq;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = direct ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = zero_run_reg ? ST_DONE : ST_DIV;
                cnt_next   = CNT_W'(PROD_W - 1);
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                dx_mag_reg   <= dx[DIFF_W-1]   ? DIFF_W'(-dx)   : DIFF_W'(dx);
                rise_mag_reg <= rise[DIFF_W-1] ? DIFF_W'(-rise) : DIFF_W'(rise);
                run_mag_reg  <= run[DIFF_W-1]  ? DIFF_W'(-run)  : DIFF_W'(run);
                neg_reg      <= dx[DIFF_W-1] ^ rise[DIFF_W-1] ^ run[DIFF_W-1];
                zero_run_reg <= run == '0;
                ya_reg       <= ya;
                value_reg    <= direct ? direct_value : '0;
                sat_reg      <= 1'b0;
            end
            ST_MUL:
            begin
                quo_reg <= dx_mag_reg * rise_mag_reg;
                rem_reg <= '0;
            end
            ST_DIV:
            begin
                quo_reg <= {quo_reg[PROD_W-2:0], fits};
                if (fits)
                begin
                    rem_reg <= trial[DIFF_W-1:0];
                end
                else
                begin
                    rem_reg <= {rem_reg[DIFF_W-2:0], quo_reg[PROD_W-1]};
                end
            end
            ST_FIN:
            begin
                if (r > HI)
                begin
                    value_reg <= HI[VALUE_BITS-1:0];
                    sat_reg   <= 1'b1;
                end
                else if (r < LO)
                begin
                    value_reg <= LO[VALUE_BITS-1:0];
                    sat_reg   <= 1'b1;
                end
                else
                begin
                    value_reg <= r[VALUE_BITS-1:0];
                    sat_reg   <= 1'b0;
                end
            end
            ST_DONE:
            begin
                sat_reg <= sat_reg;
            end
            default:
            begin
                sat_reg <= 1'b0;
            end
        endcase
    end

    assign res_valid = state_reg == ST_DONE;
    assign res_value = value_reg;
    assign res_sat   = sat_reg;

endmodule

@@ rtl/core/table_piecewise_linear_scale.sv @@
// top level: piecewise linear calibration table with a chain of point cells
`timescale 1ns / 1ps
// Input channel (item_valid / item_stall) carries cmd, point_index, x_value and
// y_value. A write word (cmd 0) stores one table point in the cell at
// point_index in the cycle it is accepted and gives no result. A convert
// word (cmd 1) yields one result word (scaled_value, saturated) on the
// result channel (result_valid / result_stall).
// A convert word walks the chain of MAX_POINTS cells, one cell per cycle,
// then the line unit multiplies, divides one quotient bit per cycle for a
// 2*(VALUE_BITS+1)-bit quotient, adds ya and saturates. An exact hit or an
// empty table skips the line arithmetic, and equal x ends skip everything
// after the multiply; result_valid rises once the result is in the output
// register. One convert is in flight at a time; item_stall is high from its
// acceptance until its result enters the output register, so the next word
// can be taken as soon as that result is there. Write words are taken in any
// cycle that item_stall is low.
// The output register holds a result while result_stall is high; the next
// convert may already run and waits at the end of the line unit.
// Reset clears point_count and all handshake state; table points are
// undefined until written. point_count sits at APB byte address 0.
module table_piecewise_linear_scale
    import tpls_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic [CMD_W-1:0]             cmd,
    input  logic [INDEX_W-1:0]           point_index,
    input  logic signed [VALUE_BITS-1:0] x_value,
    input  logic signed [VALUE_BITS-1:0] y_value,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [VALUE_BITS-1:0] scaled_value,
    output logic                         saturated
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    logic [COUNT_REG_W-1:0] point_count_reg;
    logic                   busy_reg, busy_next;
    logic                   out_valid_reg, out_valid_next;
    logic signed [VALUE_BITS-1:0] out_value_reg;
    logic                   out_sat_reg;

    logic             item_accept;
    logic             cfg_write;
    logic [CNT_W-1:0] n_eff;

    tpls_ctl_t                    ctl_c [0:MAX_POINTS];
    logic signed [VALUE_BITS-1:0] x_c   [0:MAX_POINTS];
    logic signed [VALUE_BITS-1:0] xa_c  [0:MAX_POINTS];
    logic signed [VALUE_BITS-1:0] ya_c  [0:MAX_POINTS];
    logic signed [VALUE_BITS-1:0] xb_c  [0:MAX_POINTS];
    logic signed [VALUE_BITS-1:0] yb_c  [0:MAX_POINTS];

    tpls_ctl_t                    tail;
    logic                         line_direct;
    logic signed [VALUE_BITS-1:0] line_direct_value;
    logic signed [VALUE_BITS-1:0] line_xa, line_ya, line_xb, line_yb;
    logic                         res_valid;
    logic signed [VALUE_BITS-1:0] res_value;
    logic                         res_sat;
    logic                         take;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
        end
        else if (cfg_write && paddr[2] == REG_POINT_COUNT)
        begin
            point_count_reg <= pwdata[COUNT_REG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_POINT_COUNT) ? APB_DATA_W'(point_count_reg) : '0;

    // counts above the table size act as the full table
    assign n_eff = (32'(point_count_reg) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                             : CNT_W'(point_count_reg);

    assign item_stall  = busy_reg;
    assign item_accept = item_valid && !item_stall;

    // head of the chain
    always_comb
    begin
        ctl_c[0]       = '0;
        ctl_c[0].valid = item_accept && cmd == CMD_CONVERT;
        x_c[0]         = x_value;
        xa_c[0]        = '0;
        ya_c[0]        = '0;
        xb_c[0]        = '0;
        yb_c[0]        = '0;
    end

    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        logic wr_en;

        assign wr_en = item_accept && cmd == CMD_WRITE && 32'(point_index) == i;

        tpls_cell #(
            .IDX        (i),
            .MAX_POINTS (MAX_POINTS),
            .VALUE_BITS (VALUE_BITS),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (wr_en),
            .wr_x    (x_value),
            .wr_y    (y_value),
            .n_eff   (n_eff),
            .ctl_in  (ctl_c[i]),
            .x_in    (x_c[i]),
            .xa_in   (xa_c[i]),
            .ya_in   (ya_c[i]),
            .xb_in   (xb_c[i]),
            .yb_in   (yb_c[i]),
            .ctl_out (ctl_c[i+1]),
            .x_out   (x_c[i+1]),
            .xa_out  (xa_c[i+1]),
            .ya_out  (ya_c[i+1]),
            .xb_out  (xb_c[i+1]),
            .yb_out  (yb_c[i+1])
        );
    end

    // tail of the chain: pick the segment or the direct answer
    assign tail = ctl_c[MAX_POINTS];

    always_comb
    begin
        line_direct       = (n_eff == '0) || tail.exact;
        line_direct_value = (n_eff == '0) ? '0 : ya_c[MAX_POINTS];
        if (!tail.done)
        begin
            // above every point: through the origin and the last point
            line_xa = '0;
            line_ya = '0;
            line_xb = xa_c[MAX_POINTS];
            line_yb = ya_c[MAX_POINTS];
        end
        else
        begin
            line_xa = xa_c[MAX_POINTS];
            line_ya = ya_c[MAX_POINTS];
            line_xb = xb_c[MAX_POINTS];
            line_yb = yb_c[MAX_POINTS];
        end
    end

    tpls_line #(
        .VALUE_BITS (VALUE_BITS)
    ) u_line (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (tail.valid),
        .direct       (line_direct),
        .direct_value (line_direct_value),
        .x            (x_c[MAX_POINTS]),
        .xa           (line_xa),
        .ya           (line_ya),
        .xb           (line_xb),
        .yb           (line_yb),
        .take         (take),
        .res_valid    (res_valid),
        .res_value    (res_value),
        .res_sat      (res_sat)
    );

    // output register
    assign take = res_valid && (!out_valid_reg || !result_stall);

    always_comb
    begin
        busy_next = busy_reg;
        if (item_accept && cmd == CMD_CONVERT)
        begin
            busy_next = 1'b1;
        end
        else if (take)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_value_reg <= res_value;
            out_sat_reg   <= res_sat;
        end
    end

    assign result_valid = out_valid_reg;
    assign scaled_value = out_value_reg;
    assign saturated    = out_sat_reg;

endmodule
